// ----- rtl/kabf_pkg.sv -----
// Shared types, constants and the saturation helper function of the angle/bias filter.
package kabf_pkg;

   localparam logic [31:0] ANGLE_RESET     = 32'sd11796480;
   localparam logic [31:0] Q_ANGLE_RESET   = 32'd268435;
   localparam logic [31:0] Q_BIAS_RESET    = 32'd805306;
   localparam logic [31:0] R_MEASURE_RESET = 32'd8053064;

   // register addresses (byte)
   localparam logic [3:0] ADDR_Q_ANGLE   = 4'd0;
   localparam logic [3:0] ADDR_Q_BIAS    = 4'd4;
   localparam logic [3:0] ADDR_R_MEASURE = 4'd8;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_SET    = 1'b1;

   // divider
   localparam int DIV_STEPS = 61;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RATE,
      ST_M_ANG,
      ST_ANG,
      ST_M_DP11,
      ST_INNER,
      ST_M_P00,
      ST_P00,
      ST_M_P11,
      ST_S,
      ST_DIV0,
      ST_DIV1,
      ST_Y,
      ST_M_KA,
      ST_M_KB,
      ST_M_C00,
      ST_M_C01,
      ST_M_C10,
      ST_M_C11,
      ST_OUT
   } state_type;

   // control from sequencer to divider
   typedef struct packed {
      logic start;
      logic busy;
   } div_ctl_type;

   // saturate a 66-bit signed value to signed 32 bits
   function automatic logic [31:0] sat32(input logic signed [65:0] v);
      logic [31:0] r;
      if (v > 66'sd2147483647) r = 32'h7fff_ffff;
      else if (v < -66'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ----- rtl/kalman_angle_bias_filter_core.sv -----
// Top level: register port, sequencer and state of the angle/bias filter.
// An update word runs two serial divisions when P00 + r_measure is positive
// and skips them otherwise, and a set-angle word goes straight to the result;
// req_tready is low while a word is in work and until its result has been taken.
module kalman_angle_bias_filter_core import kabf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // meas_angle, meas_rate, step_time
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // angle_out, rate_out, bias_out
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   state_type state_ff, state_in;
   logic [31:0] qa_ff, qb_ff, rm_ff;
   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in, rate_ff, rate_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in, y_ff, y_in;
   logic signed [31:0] dp_ff, dp_in;
   logic signed [34:0] t_ff, t_in;     // inner sum
   logic [32:0] s_ff, s_in;
   logic signed [31:0] ma_ff, mr_ff;
   logic [23:0] dt_ff;
   logic signed [32:0] op_a;
   logic signed [34:0] op_b;
   logic        sh28;
   logic signed [65:0] mres;
   div_ctl_type dctl;
   logic        ddone;
   logic [31:0] dquot;
   logic signed [31:0] dnum;
   logic [32:0] dden;
   logic signed [33:0] s_sum;

   // register port
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         qa_ff <= Q_ANGLE_RESET;
         qb_ff <= Q_BIAS_RESET;
         rm_ff <= R_MEASURE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr)
            ADDR_Q_ANGLE:   qa_ff <= csr_pwdata;
            ADDR_Q_BIAS:    qb_ff <= csr_pwdata;
            ADDR_R_MEASURE: rm_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (csr_paddr)
         ADDR_Q_ANGLE:   csr_prdata = qa_ff;
         ADDR_Q_BIAS:    csr_prdata = qb_ff;
         ADDR_R_MEASURE: csr_prdata = rm_ff;
         default:        csr_prdata = '0;
      endcase
   end

   // capture word
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         ma_ff  <= req_tdata[31:0];
         mr_ff  <= req_tdata[63:32];
         dt_ff  <= req_tdata[87:64];
      end
   end

   kabf_mul u_mul (
      .clock(clock), .op_a(op_a), .op_b(op_b), .shift28(sh28), .result_ff(mres)
   );

   assign dctl.start = (state_ff == ST_S) || (state_ff == ST_DIV0 && ddone);
   assign dctl.busy  = (state_ff == ST_DIV0) || (state_ff == ST_DIV1);
   assign dnum = (state_ff == ST_S) ? p00_ff : p10_ff;
   // S is still being registered when the first division starts
   assign dden = (state_ff == ST_S) ? s_sum[32:0] : s_ff;

   kabf_div u_div (
      .clock(clock), .reset(reset), .ctl(dctl), .num(dnum), .den(dden),
      .done(ddone), .quot(dquot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = req_tuser == CMD_SET ? ST_OUT : ST_RATE;
         ST_RATE:   state_in = ST_M_ANG;
         ST_M_ANG:  state_in = ST_ANG;
         ST_ANG:    state_in = ST_M_DP11;
         ST_M_DP11: state_in = ST_INNER;
         ST_INNER:  state_in = ST_M_P00;
         ST_M_P00:  state_in = ST_P00;
         ST_P00:    state_in = ST_M_P11;
         ST_M_P11:  state_in = ST_S;
         ST_S:      state_in = s_sum > 34'sd0 ? ST_DIV0 : ST_Y;
         ST_DIV0:   if (ddone) state_in = ST_DIV1;
         ST_DIV1:   if (ddone) state_in = ST_Y;
         ST_Y:      state_in = ST_M_KA;
         ST_M_KA:   state_in = ST_M_KB;
         ST_M_KB:   state_in = ST_M_C00;
         ST_M_C00:  state_in = ST_M_C01;
         ST_M_C01:  state_in = ST_M_C10;
         ST_M_C10:  state_in = ST_M_C11;
         ST_M_C11:  state_in = ST_OUT;
         ST_OUT:    if (rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign s_sum = 34'(p00_ff) + 34'(signed'({1'b0, rm_ff}));

   // datapath per state; multiplier result lands one state later
   always_comb begin
      ang_in = ang_ff; bias_in = bias_ff; rate_in = rate_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      k0_in = k0_ff; k1_in = k1_ff; y_in = y_ff; dp_in = dp_ff;
      t_in = t_ff; s_in = s_ff;
      op_a = '0; op_b = '0; sh28 = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid && req_tuser == CMD_SET) ang_in = req_tdata[31:0];
         ST_RATE: rate_in = sat32(66'(mr_ff) - 66'(bias_ff));
         ST_M_ANG: begin
            op_a = 33'({9'd0, dt_ff}); op_b = 35'(rate_ff);
         end
         ST_ANG: begin
            ang_in = sat32(66'(ang_ff) + mres);
            op_a = 33'({9'd0, dt_ff}); op_b = 35'(p11_ff);
         end
         ST_M_DP11: dp_in = mres[31:0];
         ST_INNER: begin
            t_in = 35'(dp_ff) - 35'(p01_ff) - 35'(p10_ff) + 35'(signed'({1'b0, qa_ff}));
         end
         ST_M_P00: begin
            op_a = 33'({9'd0, dt_ff}); op_b = t_ff;
         end
         ST_P00: begin
            p00_in = sat32(66'(p00_ff) + mres);
            p01_in = sat32(66'(p01_ff) - 66'(dp_ff));
            p10_in = sat32(66'(p10_ff) - 66'(dp_ff));
            op_a = 33'({9'd0, dt_ff}); op_b = 35'({1'b0, qb_ff});
         end
         ST_M_P11: p11_in = sat32(66'(p11_ff) + mres);
         ST_S: begin
            s_in = s_sum[32:0];
            k0_in = '0; k1_in = '0;
         end
         ST_DIV0: if (ddone) k0_in = dquot;
         ST_DIV1: if (ddone) k1_in = dquot;
         ST_Y: begin
            y_in = sat32(66'(ma_ff) - 66'(ang_ff));
            op_a = 33'(k0_ff);
            op_b = 35'(signed'(sat32(66'(ma_ff) - 66'(ang_ff))));
            sh28 = 1'b1;
         end
         ST_M_KA: begin
            ang_in = sat32(66'(ang_ff) + mres);
            op_a = 33'(k1_ff); op_b = 35'(y_ff); sh28 = 1'b1;
         end
         ST_M_KB: begin
            bias_in = sat32(66'(bias_ff) + mres);
            op_a = 33'(k0_ff); op_b = 35'(p00_ff); sh28 = 1'b1;
         end
         ST_M_C00: begin
            op_a = 33'(k0_ff); op_b = 35'(p01_ff); sh28 = 1'b1;
            dp_in = sat32(66'(p00_ff) - mres);   // hold new P00
            y_in = p01_ff;                       // hold old P01
         end
         ST_M_C01: begin
            op_a = 33'(k1_ff); op_b = 35'(p00_ff); sh28 = 1'b1;
            p01_in = sat32(66'(p01_ff) - mres);
         end
         ST_M_C10: begin
            op_a = 33'(k1_ff); op_b = 35'(y_ff); sh28 = 1'b1;
            p10_in = sat32(66'(p10_ff) - mres);
         end
         ST_M_C11: begin
            p11_in = sat32(66'(p11_ff) - mres);
            p00_in = dp_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ang_ff <= ANGLE_RESET;
         bias_ff <= '0; rate_ff <= '0;
         p00_ff <= '0; p01_ff <= '0; p10_ff <= '0; p11_ff <= '0;
      end else begin
         state_ff <= state_in;
         ang_ff <= ang_in; bias_ff <= bias_in; rate_ff <= rate_in;
         p00_ff <= p00_in; p01_ff <= p01_in; p10_ff <= p10_in; p11_ff <= p11_in;
      end
      k0_ff <= k0_in; k1_ff <= k1_in; y_ff <= y_in; dp_ff <= dp_in;
      t_ff <= t_in; s_ff <= s_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {bias_ff, rate_ff, ang_ff};

`ifndef SYNTHESIS
   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_S |=> !ddone) else $error("divider done too early");
`endif
endmodule

// ----- rtl/kabf_mul.sv -----
// Shared signed 33x35 multiplier with rounding right shift.
module kabf_mul import kabf_pkg::*; (
   input  logic                clock,
   input  logic signed [32:0]  op_a,
   input  logic signed [34:0]  op_b,
   input  logic                shift28,    // 1: shift 28, 0: shift 24
   output logic signed [65:0]  result_ff   // rounded, sign extended
);
   logic signed [65:0] prod;
   logic signed [65:0] rnd;
   logic signed [65:0] result_in;

   // product, round half up, arithmetic shift
   always_comb begin
      prod = 66'(op_a) * 66'(op_b);
      if (shift28) begin
         rnd = prod + 66'sd134217728;
         result_in = rnd >>> 28;
      end else begin
         rnd = prod + 66'sd8388608;
         result_in = rnd >>> 24;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end
endmodule

// ----- rtl/kabf_div.sv -----
// Restoring divider: (num << 28) / den, truncated, saturated to 32 bits.
module kabf_div import kabf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  div_ctl_type        ctl,
   input  logic signed [31:0] num,
   input  logic [32:0]        den,        // positive
   output logic               done,
   output logic [31:0]        quot
);
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        neg_ff, neg_in;
   logic [60:0] dvd_ff, dvd_in;   // dividend bits shift out
   logic [60:0] q_ff, q_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [34:0] trial;
   logic [31:0] mag;
   logic signed [65:0] sq;

   // one quotient bit a cycle
   always_comb begin
      cnt_in = cnt_ff;
      run_in = run_ff;
      neg_in = neg_ff;
      dvd_in = dvd_ff;
      q_in   = q_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      trial  = {rem_ff, dvd_ff[60]} - {2'b0, den_ff};
      mag    = num[31] ? (32'd0 - num) : num;
      if (ctl.start) begin
         run_in = 1'b1;
         cnt_in = 6'(DIV_STEPS);
         neg_in = num[31];
         dvd_in = {1'b0, mag, 28'd0};
         q_in   = '0;
         rem_in = '0;
         den_in = den;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[59:0], 1'b0};
         if (!trial[34]) begin
            rem_in = trial[33:0];
            q_in   = {q_ff[59:0], 1'b1};
         end else begin
            rem_in = {rem_ff[32:0], dvd_ff[60]};
            q_in   = {q_ff[59:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      neg_ff <= neg_in;
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // signed, saturated quotient
   always_comb begin
      sq   = neg_ff ? -66'(signed'({1'b0, q_ff})) : 66'(signed'({1'b0, q_ff}));
      quot = sat32(sq);
      done = !run_ff && ctl.busy;
   end
endmodule

// ----- bench/tb_kalman_angle_bias_filter_core.sv -----
// Self-checking bench for the angle/bias filter core: driver, monitor and filter predictor.
`timescale 1ns / 1ps

module tb_kalman_angle_bias_filter_core import kabf_pkg::*;;

   // packed so that {req_tuser, req_tdata} lines up
   typedef struct packed {
      logic        cmd;
      logic [23:0] step_time;
      logic [31:0] meas_rate;
      logic [31:0] meas_angle;
   } filter_word_type;

   // packed in the order of rsp_tdata, angle lowest
   typedef struct packed {
      logic [31:0] bias;
      logic [31:0] rate;
      logic [31:0] angle;
   } estimate_type;

   localparam int CYCLE_LIMIT = 900000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   kalman_angle_bias_filter_core uut (.*);

   // predictor state
   logic [31:0] cfg_q_angle, cfg_q_bias, cfg_r_measure;
   logic signed [31:0] est_angle, est_bias, est_rate;
   logic signed [31:0] cov [4];

   filter_word_type pending_words [$];
   estimate_type    expected_estimates [$];

   int  mismatches;
   int  cycle_count;
   bit  quiet_phase;
   int  hold_off_cycles;
   int  send_gap, recv_gap;

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // round-to-nearest right shift, ties toward plus infinity
   function automatic logic signed [127:0] round_shift(input logic signed [127:0] v, input int s);
      logic signed [127:0] t;
      t = v + (128'sd1 <<< (s - 1));
      return t >>> s;
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'sh7fff_ffff;
      if (v < -128'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // advance the filter by one word and return the expected estimate
   function automatic estimate_type filter_predict(input filter_word_type w);
      logic signed [127:0] dt, p00, p01, p10, p11, dp11, inner, s, k0, k1, y;
      logic signed [127:0] mr, ma, num;
      estimate_type e;
      ma = $signed(w.meas_angle);
      if (w.cmd == CMD_SET) begin
         est_angle = w.meas_angle;
      end else begin
         mr = $signed(w.meas_rate);
         dt = {104'd0, w.step_time};
         p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
         est_rate = clamp32(mr - est_bias);
         est_angle = clamp32(est_angle + round_shift(dt * est_rate, 24));
         dp11 = round_shift(dt * p11, 24);
         inner = dp11 - p01 - p10 + $signed({96'd0, cfg_q_angle});
         p00 = clamp32(p00 + round_shift(dt * inner, 24));
         p01 = clamp32(p01 - dp11);
         p10 = clamp32(p10 - dp11);
         p11 = clamp32(p11 + round_shift($signed({96'd0, cfg_q_bias}) * dt, 24));
         s = p00 + $signed({96'd0, cfg_r_measure});
         k0 = 0; k1 = 0;
         if (s > 0) begin
            num = p00 <<< 28;
            k0 = clamp32(num / s);
            num = p10 <<< 28;
            k1 = clamp32(num / s);
         end
         y = clamp32(ma - est_angle);
         est_angle = clamp32(est_angle + round_shift(k0 * y, 28));
         est_bias = clamp32(est_bias + round_shift(k1 * y, 28));
         cov[0] = clamp32(p00 - round_shift(k0 * p00, 28));
         cov[1] = clamp32(p01 - round_shift(k0 * p01, 28));
         cov[2] = clamp32(p10 - round_shift(k1 * p00, 28));
         cov[3] = clamp32(p11 - round_shift(k1 * p01, 28));
      end
      e.angle = est_angle;
      e.rate = est_rate;
      e.bias = est_bias;
      return e;
   endfunction

   // random field with a bias toward extremes
   function automatic logic [31:0] edgy32();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return $urandom();
         default: return $signed($urandom_range(0, 2 * 23592960)) - 23592960;
      endcase
   endfunction

   function automatic filter_word_type random_word();
      filter_word_type w;
      w.cmd = ($urandom_range(0, 9) == 0) ? CMD_SET : CMD_UPDATE;
      w.meas_angle = edgy32();
      w.meas_rate = edgy32();
      case ($urandom_range(0, 5))
         0: w.step_time = 24'hff_ffff;
         1: w.step_time = 24'd0;
         2: w.step_time = 24'($urandom());
         default: w.step_time = 24'($urandom_range(0, 400000));
      endcase
      return w;
   endfunction

   // driver: input words
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
               send_gap <= $urandom_range(0, 6);
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               {req_tuser, req_tdata} <= pending_words[0];
               expected_estimates.push_back(filter_predict(pending_words.pop_front()));
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap <= 0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         recv_gap <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: compare result words against the oldest expectation
   always @(posedge clock) begin
      estimate_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_estimates.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected result word %h", got);
         end else begin
            want = expected_estimates.pop_front();
            if (got.angle !== want.angle || got.rate !== want.rate ||
                got.bias !== want.bias) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: angle %h/%h rate %h/%h bias %h/%h (exp/act)",
                           want.angle, got.angle, want.rate, got.rate,
                           want.bias, got.bias);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_kalman_angle_bias_filter_core failed");
         $finish;
      end
   end

   task automatic csr_write(input logic [3:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == ADDR_Q_ANGLE) cfg_q_angle = data;
      else if (addr == ADDR_Q_BIAS) cfg_q_bias = data;
      else if (addr == ADDR_R_MEASURE) cfg_r_measure = data;
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || expected_estimates.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic push_word(input logic cmd, input logic [31:0] a, input logic [31:0] r,
                            input logic [23:0] dt);
      filter_word_type w;
      w.cmd = cmd; w.meas_angle = a; w.meas_rate = r; w.step_time = dt;
      pending_words.push_back(w);
   endtask

   initial begin
      logic [31:0] q_angle_set [4];
      logic [31:0] q_bias_set  [4];
      logic [31:0] r_set       [4];
      q_angle_set = '{32'd268435, 32'd0, 32'hffff_ffff, 32'd2684354};
      q_bias_set  = '{32'd805306, 32'hffff_ffff, 32'd0, 32'd80530};
      r_set       = '{32'd8053064, 32'd1, 32'hffff_ffff, 32'd0};
      reset = 1'b1;
      req_tdata = '0; req_tuser = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      mismatches = 0; cycle_count = 0; quiet_phase = 1'b0; hold_off_cycles = 0;
      cfg_q_angle = Q_ANGLE_RESET; cfg_q_bias = Q_BIAS_RESET; cfg_r_measure = R_MEASURE_RESET;
      est_angle = ANGLE_RESET; est_bias = 0; est_rate = 0;
      foreach (cov[i]) cov[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, field extremes, set angle
      push_word(CMD_UPDATE, 32'd0, 32'd0, 24'd0);
      push_word(CMD_UPDATE, 32'h7fff_ffff, 32'h7fff_ffff, 24'hff_ffff);
      push_word(CMD_UPDATE, 32'h8000_0000, 32'h8000_0000, 24'hff_ffff);
      push_word(CMD_SET, 32'h8000_0000, 32'hffff_ffff, 24'hff_ffff);
      push_word(CMD_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 24'd167772);
      push_word(CMD_SET, 32'h7fff_ffff, 32'h0, 24'd0);
      push_word(CMD_UPDATE, 32'hffff_ffff, 32'h0001_0000, 24'd167772);
      push_word(CMD_SET, 32'd0, 32'h5555_5555, 24'haa_aaaa);
      for (int i = 0; i < 6; i++) push_word(CMD_UPDATE, 32'd655360, 32'd65536, 24'd167772);
      drain();

      // zero r_measure, q_angle and q_bias with an update word at zero step
      csr_write(ADDR_R_MEASURE, 32'd0);
      csr_write(ADDR_Q_ANGLE, 32'd0);
      csr_write(ADDR_Q_BIAS, 32'd0);
      push_word(CMD_UPDATE, 32'd100, 32'd200, 24'd0);
      drain();

      // random phases over several settings
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(ADDR_Q_ANGLE, q_angle_set[ph]);
         csr_write(ADDR_Q_BIAS, q_bias_set[ph]);
         csr_write(ADDR_R_MEASURE, r_set[ph]);
         if (ph == 3) quiet_phase = 1'b1;
         for (int i = 0; i < 270; i++) pending_words.push_back(random_word());
         if (ph == 1) begin
            // long receiver hold-off while words keep being offered
            while (pending_words.size() > 260) @(posedge clock);
            hold_off_cycles = 400;
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("tb_kalman_angle_bias_filter_core passed");
      end else begin
         $display("tb_kalman_angle_bias_filter_core failed");
      end
      $finish;
   end

endmodule
